>>> hw/rtl/etl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ERE token lexer.
// Used by etl_lex_core, etl_out_queue and ere_token_lexer; depends on nothing.
package etl_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int PAREN_WIDTH = 8;
    localparam int PROD_WIDTH  = COUNT_WIDTH + 4;
    localparam int VALUE_WIDTH = 16;

    // token kinds
    localparam logic [2:0] KIND_ORD     = 3'd0;
    localparam logic [2:0] KIND_QUOTED  = 3'd1;
    localparam logic [2:0] KIND_COUNT   = 3'd2;
    localparam logic [2:0] KIND_SPECIAL = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;

    // pattern characters
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [1:0] {
        CTX_PLAIN  = 2'd0,
        CTX_REPEAT = 2'd1,
        CTX_SET    = 2'd2
    } ctx_t;

    typedef enum logic [1:0] {
        PEND_NONE   = 2'd0,
        PEND_ESC    = 2'd1,
        PEND_DIGITS = 2'd2,
        PEND_DASH   = 2'd3
    } pend_t;

    typedef struct packed {
        ctx_t                   ctx;
        logic [1:0]             pos;
        logic                   neg;
        logic [PAREN_WIDTH-1:0] paren;
        pend_t                  pend;
        logic [COUNT_WIDTH-1:0] acc;
    } lex_state_t;

    typedef struct packed {
        logic [2:0]             kind;
        logic [VALUE_WIDTH-1:0] value;
        logic                   err;
        logic                   last;
    } tok_t;

    // up to two tokens caused by one input beat, tok0 first
    typedef struct packed {
        logic v0;
        logic v1;
        tok_t tok0;
        tok_t tok1;
    } tok_pair_t;

endpackage

>>> hw/rtl/etl_lex_core.sv
`timescale 1ns / 1ps
// Combinational lexer step: next lexer state and up to two tokens per byte.
// Depends on etl_pkg.
module etl_lex_core
    import etl_pkg::*;
(
    input  lex_state_t cur,
    input  logic [7:0] data_byte,
    input  logic       end_of_input,
    output lex_state_t nxt,
    output tok_pair_t  toks
);

    typedef struct packed {
        lex_state_t st;
        logic       emit;
        tok_t       tok;
    } take_t;

    function automatic tok_t mk_tok(logic [2:0] k, logic [VALUE_WIDTH-1:0] v);
        tok_t t;
        t.kind  = k;
        t.value = v;
        t.err   = 1'b0;
        t.last  = 1'b0;
        return t;
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_quotable(logic [7:0] b);
        return (b == CH_BSLASH) || (b == CH_CARET) || (b == CH_DOT) || (b == CH_LBRACK)
            || (b == CH_DOLLAR) || (b == CH_LPAREN) || (b == CH_RPAREN) || (b == CH_PIPE)
            || (b == CH_STAR) || (b == CH_PLUS) || (b == CH_QUEST) || (b == CH_LBRACE);
    endfunction

    // Classify a byte that opens a new token.
    function automatic take_t take_byte(lex_state_t s, logic [7:0] b);
        take_t      r;
        logic       inset;
        logic [1:0] rel;
        logic [7:0] dig;
        r.st   = s;
        r.emit = 1'b1;
        r.tok  = mk_tok(KIND_ORD, VALUE_WIDTH'(b));
        inset  = (s.ctx == CTX_SET);
        dig    = b - CH_ZERO;
        if (inset && (s.pos != 2'd3))
        begin
            r.st.pos = s.pos + 2'd1;
        end
        rel = r.st.pos - {1'b0, s.neg};
        case (b)
            CH_BSLASH:
            begin
                r.st.pend = PEND_ESC;
                r.emit    = 1'b0;
            end
            CH_RPAREN:
            begin
                if (s.paren != '0)
                begin
                    r.st.paren = s.paren - PAREN_WIDTH'(1);
                    r.tok.kind = inset ? KIND_ORD : KIND_SPECIAL;
                end
            end
            CH_LPAREN:
            begin
                if (s.paren != '1)
                begin
                    r.st.paren = s.paren + PAREN_WIDTH'(1);
                end
                r.tok.kind = inset ? KIND_ORD : KIND_SPECIAL;
            end
            CH_CARET, CH_DOT, CH_LBRACK, CH_DOLLAR, CH_PIPE,
            CH_STAR, CH_PLUS, CH_QUEST, CH_LBRACE:
            begin
                if (!inset)
                begin
                    r.tok.kind = KIND_SPECIAL;
                    // refuse a context switch unless in plain context
                    if (b == CH_LBRACE)
                    begin
                        if (s.ctx != CTX_PLAIN)
                        begin
                            r.tok.err = 1'b1;
                        end
                        else
                        begin
                            r.st.ctx = CTX_REPEAT;
                        end
                    end
                    else if (b == CH_LBRACK)
                    begin
                        if (s.ctx != CTX_PLAIN)
                        begin
                            r.tok.err = 1'b1;
                        end
                        else
                        begin
                            r.st.ctx = CTX_SET;
                            r.st.pos = 2'd0;
                            r.st.neg = 1'b0;
                        end
                    end
                end
                else if ((b == CH_CARET) && (r.st.pos == 2'd1))
                begin
                    r.st.neg   = 1'b1;
                    r.tok.kind = KIND_SPECIAL;
                end
            end
            CH_RBRACK:
            begin
                if (inset && (rel != 2'd1))
                begin
                    r.st.ctx   = CTX_PLAIN;
                    r.tok.kind = KIND_SPECIAL;
                end
            end
            CH_DASH:
            begin
                if (inset && (rel != 2'd1))
                begin
                    r.st.pend = PEND_DASH;
                    r.emit    = 1'b0;
                end
            end
            CH_RBRACE:
            begin
                if (s.ctx == CTX_REPEAT)
                begin
                    r.st.ctx   = CTX_PLAIN;
                    r.tok.kind = KIND_SPECIAL;
                end
            end
            CH_COMMA:
            begin
                if (s.ctx == CTX_REPEAT)
                begin
                    r.tok.kind = KIND_SPECIAL;
                end
            end
            default:
            begin
                if (is_digit(b) && (s.ctx == CTX_REPEAT))
                begin
                    r.st.pend = PEND_DIGITS;
                    r.st.acc  = COUNT_WIDTH'(dig);
                    r.emit    = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

    lex_state_t             cleared;
    take_t                  tb;
    tok_t                   esc_tok;
    tok_t                   cnt_tok;
    tok_t                   end_tok;
    logic [7:0]             dig;
    logic [PROD_WIDTH-1:0]  prod;

    always_comb
    begin
        cleared      = cur;
        cleared.pend = PEND_NONE;
        tb           = take_byte(cleared, data_byte);
        esc_tok      = mk_tok((cur.ctx == CTX_SET) ? KIND_ORD : KIND_SPECIAL,
                              VALUE_WIDTH'(CH_BSLASH));
        cnt_tok      = mk_tok(KIND_COUNT, VALUE_WIDTH'(cur.acc));
        end_tok      = mk_tok(KIND_END, '0);
        dig          = data_byte - CH_ZERO;
        // acc * 10 + digit, then saturate
        prod = ({4'b0000, cur.acc} << 3) + ({4'b0000, cur.acc} << 1)
             + PROD_WIDTH'(dig);

        nxt  = cur;
        toks = '0;
        if (end_of_input)
        begin
            nxt = cleared;
            case (cur.pend)
                PEND_ESC:
                begin
                    toks.v0 = 1'b1; toks.tok0 = esc_tok;
                    toks.v1 = 1'b1; toks.tok1 = end_tok;
                end
                PEND_DIGITS:
                begin
                    toks.v0 = 1'b1; toks.tok0 = cnt_tok;
                    toks.v1 = 1'b1; toks.tok1 = end_tok;
                end
                PEND_DASH:
                begin
                    toks.v0 = 1'b1; toks.tok0 = mk_tok(KIND_SPECIAL, VALUE_WIDTH'(CH_DASH));
                    toks.v1 = 1'b1; toks.tok1 = end_tok;
                end
                default:
                begin
                    toks.v0 = 1'b1; toks.tok0 = end_tok;
                end
            endcase
        end
        else
        begin
            case (cur.pend)
                PEND_ESC:
                begin
                    if (is_quotable(data_byte))
                    begin
                        nxt     = cleared;
                        toks.v0 = 1'b1;
                        toks.tok0 = mk_tok(KIND_QUOTED, VALUE_WIDTH'(data_byte));
                    end
                    else
                    begin
                        nxt       = tb.st;
                        toks.v0   = 1'b1;
                        toks.tok0 = esc_tok;
                        toks.v1   = tb.emit;
                        toks.tok1 = tb.tok;
                    end
                end
                PEND_DIGITS:
                begin
                    if (is_digit(data_byte))
                    begin
                        if (|prod[PROD_WIDTH-1:COUNT_WIDTH])
                        begin
                            nxt.acc = '1;
                        end
                        else
                        begin
                            nxt.acc = prod[COUNT_WIDTH-1:0];
                        end
                    end
                    else
                    begin
                        nxt       = tb.st;
                        toks.v0   = 1'b1;
                        toks.tok0 = cnt_tok;
                        toks.v1   = tb.emit;
                        toks.tok1 = tb.tok;
                    end
                end
                PEND_DASH:
                begin
                    nxt       = tb.st;
                    toks.v0   = 1'b1;
                    toks.tok0 = mk_tok((data_byte == CH_RBRACK) ? KIND_ORD : KIND_SPECIAL,
                                       VALUE_WIDTH'(CH_DASH));
                    toks.v1   = tb.emit;
                    toks.tok1 = tb.tok;
                end
                default:
                begin
                    nxt       = tb.st;
                    toks.v0   = tb.emit;
                    toks.tok0 = tb.tok;
                end
            endcase
        end
        toks.tok0.last = !toks.v1;
        toks.tok1.last = 1'b1;
    end

endmodule

>>> hw/rtl/etl_out_queue.sv
`timescale 1ns / 1ps
// Two-entry result queue feeding the master-side stream port.
// Depends on etl_pkg.
module etl_out_queue
    import etl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  tok_pair_t  toks,
    output logic       room,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [15:0] m_axis_tdata,   // token_value[15:0]
    output logic [3:0] m_axis_tuser,    // token_kind[2:0], context_error[3]
    output logic       m_axis_tlast
);

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    tok_t       slot0_reg;
    tok_t       slot0_next;
    tok_t       slot1_reg;
    tok_t       slot1_next;
    logic       pop;

    assign pop  = (cnt_reg != 2'd0) && m_axis_tready;
    // take a new pair only when the queue is empty after this cycle's beat
    assign room = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_axis_tready);

    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (pop)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
        if (push && toks.v0)
        begin
            slot0_next = toks.tok0;
            slot1_next = toks.tok1;
            cnt_next   = toks.v1 ? 2'd2 : 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = slot0_reg.value;
    assign m_axis_tuser  = {slot0_reg.err, slot0_reg.kind};
    assign m_axis_tlast  = slot0_reg.last;

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push && toks.v0) |-> ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_axis_tready)))
        else $error("result pair pushed into a queue without room");

    a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> (!slot0_reg.last && slot1_reg.last))
        else $error("full queue must hold one pair with last on its second token");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result queue overfilled");

endmodule

>>> hw/rtl/ere_token_lexer.sv
`timescale 1ns / 1ps
// ERE token lexer top level: input register, lexer state, result queue.
// Depends on etl_pkg, etl_lex_core and etl_out_queue.
// A beat in the input register is lexed and its tokens registered into the result queue.
// Throughput: one byte per cycle while each byte yields at most one token and the output
// is ready; a byte yielding two tokens stalls the input, set by the single result port.
// Reset (async, rst_n low): plain context, no pending token, depth zero, queue empty.
module ere_token_lexer
    import etl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic        s_axis_tlast,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // token_value[15:0]
    output logic [3:0]  m_axis_tuser,   // token_kind[2:0], context_error[3]
    output logic        m_axis_tlast
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;
    lex_state_t lex_reg;
    lex_state_t lex_next;
    tok_pair_t  toks;
    logic       room;
    logic       advance;
    logic       s_fire;

    assign advance       = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || room;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    etl_lex_core u_core (
        .cur          (lex_reg),
        .data_byte    (in_byte_reg),
        .end_of_input (in_end_reg),
        .nxt          (lex_next),
        .toks         (toks)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            lex_reg      <= '{ctx: CTX_PLAIN, pos: 2'd0, neg: 1'b0, paren: '0,
                              pend: PEND_NONE, acc: '0};
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
            begin
                lex_reg <= lex_next;
            end
        end
    end

    // hold the beat until the queue can take its tokens
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_byte_reg <= s_axis_tdata;
            in_end_reg  <= s_axis_tlast;
        end
    end

    etl_out_queue u_queue (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (advance),
        .toks          (toks),
        .room          (room),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_digits_in_braces: assert property (@(posedge clk) disable iff (!rst_n)
        (lex_reg.pend == PEND_DIGITS) |-> (lex_reg.ctx == CTX_REPEAT))
        else $error("digit run pending outside repeat braces");

    a_dash_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        (lex_reg.pend == PEND_DASH) |-> (lex_reg.ctx == CTX_SET))
        else $error("bracket dash pending outside a bracket");

    a_neg_after_first: assert property (@(posedge clk) disable iff (!rst_n)
        lex_reg.neg |-> (lex_reg.pos != 2'd0))
        else $error("bracket negated before its first token");

endmodule

>>> tb/sv/ere_token_lexer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for ere_token_lexer: a clocked stream driver and monitor
// around a behavioural shadow of the lexer. It depends on etl_pkg and on the lexer RTL.
module ere_token_lexer_tb;
    import etl_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       eoi;
        bit         drain;  // offer only once every awaited token has arrived
    } pat_beat_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;  // data_byte[7:0]
    logic        s_axis_tlast  = 1'b0;   // end_of_input
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // token_value[15:0]
    logic [3:0]  m_axis_tuser;           // token_kind[2:0], context_error[3]
    logic        m_axis_tlast;

    pat_beat_t pattern_q[$];
    tok_t      awaited_tokens[$];
    tok_t      beat_tokens[$];

    int errors     = 0;
    int beats_sent = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    bit in_taken   = 1'b0;
    bit next_drain = 1'b0;

    // shadow lexer state
    ctx_t                   lx_ctx   = CTX_PLAIN;
    logic [1:0]             lx_pos   = '0;
    logic                   lx_neg   = 1'b0;
    logic [PAREN_WIDTH-1:0] lx_paren = '0;
    pend_t                  lx_pend  = PEND_NONE;
    logic [COUNT_WIDTH-1:0] lx_acc   = '0;

    ere_token_lexer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ---------------------------------------------------------------- shadow lexer

    function automatic void put_tok(input logic [2:0] kind, input logic [VALUE_WIDTH-1:0] value,
                                    input logic err);
        tok_t t;
        t.kind  = kind;
        t.value = value;
        t.err   = err;
        t.last  = 1'b0;
        beat_tokens.push_back(t);
    endfunction

    function automatic bit is_digit(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic bit is_quotable(input logic [7:0] b);
        case (b)
            CH_BSLASH, CH_CARET, CH_DOT, CH_LBRACK, CH_DOLLAR, CH_LPAREN,
            CH_RPAREN, CH_PIPE, CH_STAR, CH_PLUS, CH_QUEST, CH_LBRACE: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // refuse entry unless the lexer is in plain context
    function automatic bit enter_ctx(input ctx_t nc);
        if (lx_ctx != CTX_PLAIN)
            return 1'b0;
        lx_ctx = nc;
        if (nc == CTX_SET)
        begin
            lx_pos = '0;
            lx_neg = 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void put_escape();
        put_tok(lx_ctx == CTX_SET ? KIND_ORD : KIND_SPECIAL, VALUE_WIDTH'(CH_BSLASH), 1'b0);
    endfunction

    // a byte that starts a fresh token
    function automatic void take_byte(input logic [7:0] b);
        bit                     inset;
        int                     rel;
        bit                     err;
        logic [VALUE_WIDTH-1:0] bv;
        inset = (lx_ctx == CTX_SET);
        bv    = VALUE_WIDTH'(b);
        if (inset && lx_pos != 2'd3)
            lx_pos = lx_pos + 2'd1;
        rel = int'(lx_pos) - int'(lx_neg);
        case (b)
            CH_BSLASH: lx_pend = PEND_ESC;
            CH_RPAREN:
            begin
                if (lx_paren == '0)
                    put_tok(KIND_ORD, bv, 1'b0);
                else
                begin
                    lx_paren = lx_paren - PAREN_WIDTH'(1);
                    put_tok(inset ? KIND_ORD : KIND_SPECIAL, bv, 1'b0);
                end
            end
            CH_LPAREN:
            begin
                if (lx_paren != '1)
                    lx_paren = lx_paren + PAREN_WIDTH'(1);
                put_tok(inset ? KIND_ORD : KIND_SPECIAL, bv, 1'b0);
            end
            CH_CARET, CH_DOT, CH_LBRACK, CH_DOLLAR, CH_PIPE,
            CH_STAR, CH_PLUS, CH_QUEST, CH_LBRACE:
            begin
                if (!inset)
                begin
                    err = 1'b0;
                    if (b == CH_LBRACE)
                        err = !enter_ctx(CTX_REPEAT);
                    else if (b == CH_LBRACK)
                        err = !enter_ctx(CTX_SET);
                    put_tok(KIND_SPECIAL, bv, err);
                end
                else if (b == CH_CARET && lx_pos == 2'd1)
                begin
                    lx_neg = 1'b1;
                    put_tok(KIND_SPECIAL, bv, 1'b0);
                end
                else
                    put_tok(KIND_ORD, bv, 1'b0);
            end
            CH_RBRACK:
            begin
                if (inset && rel != 1)
                begin
                    lx_ctx = CTX_PLAIN;
                    put_tok(KIND_SPECIAL, bv, 1'b0);
                end
                else
                    put_tok(KIND_ORD, bv, 1'b0);
            end
            CH_DASH:
            begin
                if (inset && rel != 1)
                    lx_pend = PEND_DASH;
                else
                    put_tok(KIND_ORD, bv, 1'b0);
            end
            CH_RBRACE:
            begin
                if (lx_ctx == CTX_REPEAT)
                begin
                    lx_ctx = CTX_PLAIN;
                    put_tok(KIND_SPECIAL, bv, 1'b0);
                end
                else
                    put_tok(KIND_ORD, bv, 1'b0);
            end
            CH_COMMA: put_tok(lx_ctx == CTX_REPEAT ? KIND_SPECIAL : KIND_ORD, bv, 1'b0);
            default:
            begin
                if (is_digit(b) && lx_ctx == CTX_REPEAT)
                begin
                    lx_pend = PEND_DIGITS;
                    lx_acc  = COUNT_WIDTH'(b - CH_ZERO);
                end
                else
                    put_tok(KIND_ORD, bv, 1'b0);
            end
        endcase
    endfunction

    // advance the shadow by one accepted beat and queue the tokens it causes
    function automatic void lex_beat(input logic [7:0] b, input logic eoi);
        logic [31:0] prod;
        beat_tokens.delete();
        if (eoi)
        begin
            case (lx_pend)
                PEND_ESC:    put_escape();
                PEND_DIGITS: put_tok(KIND_COUNT, lx_acc, 1'b0);
                PEND_DASH:   put_tok(KIND_SPECIAL, VALUE_WIDTH'(CH_DASH), 1'b0);
                default: ;
            endcase
            lx_pend = PEND_NONE;
            put_tok(KIND_END, '0, 1'b0);
        end
        else
        begin
            case (lx_pend)
                PEND_ESC:
                begin
                    lx_pend = PEND_NONE;
                    if (is_quotable(b))
                        put_tok(KIND_QUOTED, VALUE_WIDTH'(b), 1'b0);
                    else
                    begin
                        put_escape();
                        take_byte(b);
                    end
                end
                PEND_DIGITS:
                begin
                    if (is_digit(b))
                    begin
                        // saturate instead of wrapping
                        prod = 32'(lx_acc) * 32'd10 + 32'(b - CH_ZERO);
                        if (prod > 32'({COUNT_WIDTH{1'b1}}))
                            lx_acc = '1;
                        else
                            lx_acc = prod[COUNT_WIDTH-1:0];
                    end
                    else
                    begin
                        lx_pend = PEND_NONE;
                        put_tok(KIND_COUNT, lx_acc, 1'b0);
                        take_byte(b);
                    end
                end
                PEND_DASH:
                begin
                    lx_pend = PEND_NONE;
                    put_tok(b == CH_RBRACK ? KIND_ORD : KIND_SPECIAL, VALUE_WIDTH'(CH_DASH),
                            1'b0);
                    take_byte(b);
                end
                default: take_byte(b);
            endcase
        end
        if (beat_tokens.size() != 0)
            beat_tokens[beat_tokens.size()-1].last = 1'b1;
        foreach (beat_tokens[i])
            awaited_tokens.push_back(beat_tokens[i]);
    endfunction

    // ---------------------------------------------------------------- pattern source

    function automatic void push_beat(input logic [7:0] data, input logic eoi);
        pat_beat_t pb;
        pb.data    = data;
        pb.eoi     = eoi;
        pb.drain   = next_drain;
        next_drain = 1'b0;
        pattern_q.push_back(pb);
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_beat(s[i], 1'b0);
    endfunction

    function automatic void push_end();
        push_beat(8'($urandom_range(255)), 1'b1);
    endfunction

    function automatic void push_digits(input int n);
        repeat (n)
            push_beat(8'(CH_ZERO + $urandom_range(9)), 1'b0);
    endfunction

    function automatic void push_pick(input string s);
        push_beat(s[$urandom_range(s.len() - 1)], 1'b0);
    endfunction

    // one fragment of a pattern: mostly well formed, some noise and broken pieces
    function automatic void push_fragment();
        int r;
        r = $urandom_range(99);
        if (r < 22)
            push_pick("abcxyz0159AZ_ ");
        else if (r < 34)
        begin
            push_beat(CH_BSLASH, 1'b0);
            if ($urandom_range(1))
                push_pick("\\^.[$()|*+?{");
            else
                push_beat(8'($urandom_range(255)), 1'b0);
        end
        else if (r < 46)
        begin
            push_beat(CH_LBRACE, 1'b0);
            push_digits($urandom_range(9) == 0 ? $urandom_range(5, 7) : $urandom_range(1, 3));
            if ($urandom_range(1))
            begin
                push_beat(CH_COMMA, 1'b0);
                if ($urandom_range(1))
                    push_digits($urandom_range(1, 3));
            end
            if ($urandom_range(9) != 0)
                push_beat(CH_RBRACE, 1'b0);
        end
        else if (r < 62)
        begin
            push_beat(CH_LBRACK, 1'b0);
            if ($urandom_range(1))
                push_beat(CH_CARET, 1'b0);
            if ($urandom_range(3) == 0)
                push_beat(CH_RBRACK, 1'b0);
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(2))
                    0: push_pick("abz09");
                    1: push_text("a-z");
                    default: push_pick("-()^.[{},\\");
                endcase
            end
            if ($urandom_range(3) == 0)
                push_beat(CH_DASH, 1'b0);
            if ($urandom_range(9) != 0)
                push_beat(CH_RBRACK, 1'b0);
        end
        else if (r < 72)
            push_pick("(()");
        else if (r < 80)
            push_pick("^.$|*+?");
        else if (r < 88)
            push_beat(8'($urandom_range(255)), 1'b0);
        else if (r < 93)
            push_end();
        else
            push_pick("{}[],-^\\)");
    endfunction

    function automatic int idle_pct(input bit receiver);
        if (beats_sent < 400)
            return receiver ? 57 : 37;
        else if (beats_sent < 800)
            return receiver ? 37 : 57;
        return 0;
    endfunction

    // ---------------------------------------------------------------- driver and monitor

    always @(negedge clk)
    begin : drive_input
        pat_beat_t pb;
        logic      nv;
        logic [7:0] nd;
        logic      nl;
        if (rst_n)
        begin
            nv = s_axis_tvalid;
            nd = s_axis_tdata;
            nl = s_axis_tlast;
            if (!s_axis_tvalid || in_taken)
            begin
                nv = 1'b0;
                if (pattern_q.size() != 0
                    && !(pattern_q[0].drain && awaited_tokens.size() != 0)
                    && $urandom_range(99) >= idle_pct(1'b0))
                begin
                    pb = pattern_q.pop_front();
                    nv = 1'b1;
                    nd = pb.data;
                    nl = pb.eoi;
                    beats_sent++;
                end
            end
            s_axis_tvalid <= nv;
            s_axis_tdata  <= nd;
            s_axis_tlast  <= nl;
        end
    end

    always @(negedge clk)
    begin : drive_ready
        logic nr;
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                nr = 1'b0;
            end
            else if (!hold_done && beats_sent >= 300)
            begin
                // long back-pressure so the lexer fills and stalls its input
                hold_done = 1'b1;
                hold_left = 400;
                nr        = 1'b0;
            end
            else
                nr = ($urandom_range(99) >= idle_pct(1'b1));
            m_axis_tready <= nr;
        end
    end

    always @(posedge clk)
    begin : check_output
        tok_t want;
        if (rst_n)
        begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_tokens.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected token kind %0d value %h err %b last %b", $time,
                             m_axis_tuser[2:0], m_axis_tdata, m_axis_tuser[3], m_axis_tlast);
                end
                else
                begin
                    want = awaited_tokens.pop_front();
                    if (want.kind !== m_axis_tuser[2:0] || want.value !== m_axis_tdata
                        || want.err !== m_axis_tuser[3] || want.last !== m_axis_tlast)
                    begin
                        errors++;
                        $display("%0t: kind/value/err/last expected %0d/%h/%b/%b got %0d/%h/%b/%b",
                                 $time, want.kind, want.value, want.err, want.last,
                                 m_axis_tuser[2:0], m_axis_tdata, m_axis_tuser[3], m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                lex_beat(s_axis_tdata, s_axis_tlast);
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin : run
        int  target;
        bit  drain_set;
        bit  burst_done;
        drain_set  = 1'b0;
        burst_done = 1'b0;

        // quoted pair, escape of an ordinary byte, escape then end
        push_text("\\.");
        push_text("\\a");
        push_beat(CH_BSLASH, 1'b0);
        push_end();
        // close with no group open is ordinary
        push_text("())");
        // saturating count, refused brace and bracket inside repeat braces
        push_text("{70000{[}");
        // digit run then end
        push_text("{1");
        push_end();
        // negated bracket, leading ']' is ordinary, dash then end
        push_text("[^]a-");
        push_end();
        push_beat(8'h00, 1'b0);
        push_beat(8'hFF, 1'b0);

        target = pattern_q.size() + 1150;
        while (pattern_q.size() < target)
        begin
            if (!drain_set && pattern_q.size() > 650)
            begin
                next_drain = 1'b1;
                drain_set  = 1'b1;
            end
            if (!burst_done && pattern_q.size() > 900)
            begin
                // drive the group depth into saturation
                repeat (264)
                    push_beat(CH_LPAREN, 1'b0);
                burst_done = 1'b1;
            end
            push_fragment();
        end
        push_end();

        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;

        while (pattern_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (awaited_tokens.size() != 0)
            @(posedge clk);
        repeat (50)
            @(posedge clk);

        if (errors == 0)
            $display("ere_token_lexer: match");
        else
            $display("ere_token_lexer: mismatch");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("ere_token_lexer: mismatch");
        $finish;
    end

endmodule
